FILE: rtl/rfdp_pkg.sv
// ----------------------------------------------------------------------------
// Record field directory parser package
// Shared types and constants for the controller, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfdp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIELD_COUNT  = 2'd0;
  localparam logic [1:0] CFG_VARCHAR_MASK = 2'd1;
  localparam logic [1:0] CFG_FIXED_WIDTH  = 2'd2;

  localparam logic [5:0]  FIELD_COUNT_RST = 6'd1;
  localparam logic [3:0]  FIXED_WIDTH_RST = 4'd4;
  localparam int          VARCHAR_BITS    = 32;
  localparam int          LEN_BYTES       = 4;

  typedef enum logic [1:0] {
    PH_BITMAP,
    PH_LENGTH,
    PH_BODY
  } phase_t;

  // What a field needs when the parser reaches it
  typedef enum logic [2:0] {
    K_END,
    K_NULL,
    K_FIX0,
    K_ARM_VC,
    K_ARM_FIX
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic take_byte;
    logic run_step;
  } dp_cmd_t;

  typedef struct packed {
    logic run_start;
    logic run_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/record_field_directory_parser_unit.sv
// ----------------------------------------------------------------------------
// Record field directory parser
// Parses a serialized record byte by byte into a directory of field ends.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one record byte per transaction (null bitmap, then field data).
//   out_* : one directory entry per transaction; a byte that ends a field or
//           the bitmap can release a run for following null or empty fields.
//   cfg_* : single-cycle register writes; write only between records or
//           while no entries are pending.
// Timing:
//   A byte that releases no entries leaves the controller idle, so bytes
//   stream at one per cycle. A byte that releases N entries puts it in its
//   run state, in which the field walker issues one entry per cycle into the
//   output register while that register is free, and in_stall stays high.
//   Each entry shows on out_valid in the cycle after the walker issues it.
// Reset: registers return to one field, no varchar fields, 4-byte fixed
//   fields; the parser waits for the first bitmap byte.
// Stall: out_stall holds the output register and pauses the field walker;
//   input bytes are still taken while the last entry of a run waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module record_field_directory_parser_unit import rfdp_pkg::*; #(
  parameter int MAX_FIELDS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_field_index,
  output logic [15:0]      out_end_offset,
  output logic             out_field_is_null,
  output logic             out_record_done,
  output logic [16:0]      out_record_length,
  output logic             out_oversize,
  output logic             out_last_in_run
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rfdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rfdp_dpath #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_data_byte      (in_data_byte),
    .cmd               (cmd),
    .status            (status),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_field_index   (out_field_index),
    .out_end_offset    (out_end_offset),
    .out_field_is_null (out_field_is_null),
    .out_record_done   (out_record_done),
    .out_record_length (out_record_length),
    .out_oversize      (out_oversize),
    .out_last_in_run   (out_last_in_run)
  );

endmodule

`default_nettype wire

FILE: rtl/rfdp_ctrl.sv
// ----------------------------------------------------------------------------
// Record field directory parser controller
// Decides when a byte is taken and when one directory entry is issued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfdp_ctrl import rfdp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.take_byte && status.run_start) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.run_step && status.run_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.take_byte = 1'b0;
    cmd.run_step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.take_byte = in_valid;
      end
      ST_RUN: begin
        // issue one entry each cycle the output register can take it
        cmd.run_step = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/rfdp_dpath.sv
// ----------------------------------------------------------------------------
// Record field directory parser datapath
// Configuration registers, parse state, field walker and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfdp_dpath import rfdp_pkg::*; #(
  parameter int MAX_FIELDS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [7:0]  in_data_byte,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       status,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [4:0]       out_field_index,
  output logic [15:0]      out_end_offset,
  output logic             out_field_is_null,
  output logic             out_record_done,
  output logic [16:0]      out_record_length,
  output logic             out_oversize,
  output logic             out_last_in_run
);

  localparam int CW = $clog2(MAX_FIELDS + 1);
  localparam int IW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

  // configuration
  logic [5:0]  field_count_r;
  logic [31:0] varchar_mask_r;
  logic [3:0]  fixed_width_r;

  // parse state
  phase_t                  phase_r, phase_nxt;
  logic [MAX_FIELDS-1:0]   null_mask_r, null_mask_nxt;
  logic [2:0]              bm_seen_r, bm_seen_nxt;
  logic [CW-1:0]           cur_field_r, cur_field_nxt;
  logic [31:0]             bytes_left_r, bytes_left_nxt;
  logic [31:0]             len_accum_r, len_accum_nxt;
  logic [2:0]              len_seen_r, len_seen_nxt;
  logic [16:0]             data_offset_r, data_offset_nxt;
  logic                    finish_r, finish_nxt;

  // output register
  logic        out_valid_r;
  logic [4:0]  out_field_index_r;
  logic [15:0] out_end_offset_r;
  logic        out_field_is_null_r;
  logic        out_record_done_r;
  logic [16:0] out_record_length_r;
  logic        out_oversize_r;
  logic        out_last_in_run_r;

  logic [6:0]            eff7;
  logic [CW-1:0]         cnt;
  logic [3:0]            nb;
  logic [MAX_FIELDS-1:0] mask_bm;
  logic [CW-1:0]         nxt_field;
  logic [15:0]           off_sat;
  logic                  emit_null;
  logic                  emit_done;
  logic [16:0]           bump_off;
  logic [31:0]           acc;
  logic [2:0]            lseen;
  logic [31:0]           bl_dec;
  logic [3:0]            bm_seen1;
  kind_t                 k0;
  kind_t                 kn;
  logic                  do_clear;
  logic                  run_start;
  logic                  run_last;

  function automatic logic null_at(input logic [MAX_FIELDS-1:0] m, input logic [CW-1:0] j);
    logic r;
    r = 1'b0;
    if (j < CW'(MAX_FIELDS)) r = m[j[IW-1:0]];
    return r;
  endfunction

  function automatic logic vc_at(input logic [31:0] vm, input logic [CW-1:0] j);
    logic [6:0] jx;
    logic       r;
    jx = 7'(j);
    r  = 1'b0;
    if (jx < 7'(VARCHAR_BITS)) r = vm[jx[4:0]];
    return r;
  endfunction

  function automatic kind_t classify(input logic [CW-1:0] j, input logic [CW-1:0] c,
                                     input logic is_null, input logic is_vc,
                                     input logic fw_zero);
    kind_t k;
    if (j >= c)        k = K_END;
    else if (is_null)  k = K_NULL;
    else if (is_vc)    k = K_ARM_VC;
    else if (fw_zero)  k = K_FIX0;
    else               k = K_ARM_FIX;
    return k;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_count_r  <= FIELD_COUNT_RST;
      varchar_mask_r <= '0;
      fixed_width_r  <= FIXED_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIELD_COUNT:  field_count_r  <= cfg_data[5:0];
        CFG_VARCHAR_MASK: varchar_mask_r <= cfg_data;
        CFG_FIXED_WIDTH:  fixed_width_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // effective field count and bitmap length
  always_comb begin
    if (field_count_r == 6'd0)                 eff7 = 7'd1;
    else if (7'(field_count_r) > 7'(MAX_FIELDS)) eff7 = 7'(MAX_FIELDS);
    else                                        eff7 = 7'(field_count_r);
    cnt = CW'(eff7);
    nb  = 4'((eff7 + 7'd7) >> 3);
  end

  // null mask with this bitmap byte folded in, MSB first
  always_comb begin
    for (int p = 0; p < MAX_FIELDS; p++) begin
      mask_bm[p] = (bm_seen_r == 3'd0) ? 1'b0 : null_mask_r[p];
      if (3'(p / 8) == bm_seen_r && in_data_byte[3'(7 - (p % 8))]) mask_bm[p] = 1'b1;
    end
  end

  always_comb begin
    nxt_field = cur_field_r + CW'(1);
    off_sat   = data_offset_r[16] ? 16'hFFFF : data_offset_r[15:0];
    emit_null = !finish_r && null_at(null_mask_r, cur_field_r);
    emit_done = nxt_field >= cnt;
    bump_off  = data_offset_r[16] ? data_offset_r : data_offset_r + 17'd1;
    acc       = len_accum_r | (32'(in_data_byte) << {len_seen_r[1:0], 3'b000});
    lseen     = len_seen_r + 3'd1;
    bl_dec    = (bytes_left_r != 32'd0) ? bytes_left_r - 32'd1 : 32'd0;
    bm_seen1  = 4'(bm_seen_r) + 4'd1;
    k0 = classify('0, cnt, mask_bm[0], varchar_mask_r[0], fixed_width_r == 4'd0);
    kn = classify(nxt_field, cnt, null_at(null_mask_r, nxt_field),
                  vc_at(varchar_mask_r, nxt_field), fixed_width_r == 4'd0);
  end

  always_comb begin
    phase_nxt       = phase_r;
    null_mask_nxt   = null_mask_r;
    bm_seen_nxt     = bm_seen_r;
    cur_field_nxt   = cur_field_r;
    bytes_left_nxt  = bytes_left_r;
    len_accum_nxt   = len_accum_r;
    len_seen_nxt    = len_seen_r;
    data_offset_nxt = data_offset_r;
    finish_nxt      = finish_r;
    do_clear        = 1'b0;
    run_start       = 1'b0;
    run_last        = 1'b0;

    if (cmd.take_byte) begin
      case (phase_r)
        PH_LENGTH: begin
          data_offset_nxt = bump_off;
          if (lseen >= 3'(LEN_BYTES)) begin
            bytes_left_nxt = acc;
            len_accum_nxt  = '0;
            len_seen_nxt   = '0;
            if (acc == 32'd0) begin
              run_start  = 1'b1;
              finish_nxt = 1'b1;
            end else begin
              phase_nxt = PH_BODY;
            end
          end else begin
            len_accum_nxt = acc;
            len_seen_nxt  = lseen;
          end
        end
        PH_BODY: begin
          data_offset_nxt = bump_off;
          bytes_left_nxt  = bl_dec;
          if (bl_dec == 32'd0) begin
            run_start  = 1'b1;
            finish_nxt = 1'b1;
          end
        end
        default: begin
          null_mask_nxt = mask_bm;
          if (bm_seen1 >= nb) begin
            bm_seen_nxt     = '0;
            cur_field_nxt   = '0;
            data_offset_nxt = '0;
            case (k0)
              K_NULL, K_FIX0: begin
                run_start  = 1'b1;
                finish_nxt = 1'b0;
              end
              K_ARM_VC: begin
                phase_nxt     = PH_LENGTH;
                len_accum_nxt = '0;
                len_seen_nxt  = '0;
              end
              K_ARM_FIX: begin
                bytes_left_nxt = 32'(fixed_width_r);
                phase_nxt      = PH_BODY;
              end
              default: do_clear = 1'b1;
            endcase
          end else begin
            bm_seen_nxt = bm_seen1[2:0];
          end
        end
      endcase
    end

    if (cmd.run_step) begin
      // look ahead at the next field so the last entry of a run is flagged
      case (kn)
        K_NULL, K_FIX0: begin
          cur_field_nxt = nxt_field;
          finish_nxt    = 1'b0;
        end
        K_ARM_VC: begin
          run_last      = 1'b1;
          cur_field_nxt = nxt_field;
          phase_nxt     = PH_LENGTH;
          len_accum_nxt = '0;
          len_seen_nxt  = '0;
        end
        K_ARM_FIX: begin
          run_last       = 1'b1;
          cur_field_nxt  = nxt_field;
          bytes_left_nxt = 32'(fixed_width_r);
          phase_nxt      = PH_BODY;
        end
        default: begin
          run_last = 1'b1;
          do_clear = 1'b1;
        end
      endcase
    end

    if (do_clear) begin
      phase_nxt       = PH_BITMAP;
      null_mask_nxt   = '0;
      bm_seen_nxt     = '0;
      cur_field_nxt   = '0;
      bytes_left_nxt  = '0;
      len_accum_nxt   = '0;
      len_seen_nxt    = '0;
      data_offset_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_BITMAP;
      null_mask_r   <= '0;
      bm_seen_r     <= '0;
      cur_field_r   <= '0;
      bytes_left_r  <= '0;
      len_accum_r   <= '0;
      len_seen_r    <= '0;
      data_offset_r <= '0;
      finish_r      <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      null_mask_r   <= null_mask_nxt;
      bm_seen_r     <= bm_seen_nxt;
      cur_field_r   <= cur_field_nxt;
      bytes_left_r  <= bytes_left_nxt;
      len_accum_r   <= len_accum_nxt;
      len_seen_r    <= len_seen_nxt;
      data_offset_r <= data_offset_nxt;
      finish_r      <= finish_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.run_step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_step) begin
      out_field_index_r   <= 5'(cur_field_r);
      out_end_offset_r    <= off_sat;
      out_field_is_null_r <= emit_null;
      out_record_done_r   <= emit_done;
      out_record_length_r <= emit_done ? 17'(nb) + 17'(off_sat) : 17'd0;
      out_oversize_r      <= data_offset_r[16];
      out_last_in_run_r   <= run_last;
    end
  end

  assign status.run_start = run_start;
  assign status.run_last  = run_last;
  assign status.out_free  = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_field_index   = out_field_index_r;
  assign out_end_offset    = out_end_offset_r;
  assign out_field_is_null = out_field_is_null_r;
  assign out_record_done   = out_record_done_r;
  assign out_record_length = out_record_length_r;
  assign out_oversize      = out_oversize_r;
  assign out_last_in_run   = out_last_in_run_r;

endmodule

`default_nettype wire

FILE: verif/record_field_directory_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// Record field directory parser testbench
// Streams serialized records into the parser and checks every directory
// entry against a cycle-free model of the field walk: null bitmap decode,
// fixed and length-prefixed fields, null runs and layout changes between
// transaction bursts. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module record_field_directory_parser_unit_tb;
  import rfdp_pkg::*;

  localparam int FIELD_LIMIT = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    phase_t      phase;
    logic [63:0] null_bits;
    logic [3:0]  bitmap_seen;
    logic [6:0]  field_cur;
    logic [31:0] remaining;
    logic [31:0] len_acc;
    logic [2:0]  len_seen;
    logic [16:0] offset;
  } parser_state_t;

  typedef struct packed {
    logic [4:0]  field_index;
    logic [15:0] end_offset;
    logic        is_null;
    logic        done;
    logic [16:0] rec_len;
    logic        oversize;
    logic        last_in_run;
  } dir_entry_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_field_index;
  logic [15:0] out_end_offset;
  logic        out_field_is_null;
  logic        out_record_done;
  logic [16:0] out_record_length;
  logic        out_oversize;
  logic        out_last_in_run;

  // layout as the parser sees it
  logic [5:0]  cfg_fields;
  logic [31:0] cfg_varchar;
  logic [3:0]  cfg_fixed;

  parser_state_t live_parser;
  parser_state_t shadow_parser;
  dir_entry_t    step_entries[$];
  dir_entry_t    expected_entries[$];
  logic [7:0]    pending_bytes[$];

  int send_idle_pct;
  int stall_pct;
  int bytes_pushed;
  int bytes_taken;
  int gen_entries;
  int entries_checked;
  int records_closed;
  int cfg_writes;
  int mismatch_count;
  int cycle_count;

  record_field_directory_parser_unit #(.MAX_FIELDS(FIELD_LIMIT)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_field_index  (out_field_index),
    .out_end_offset   (out_end_offset),
    .out_field_is_null(out_field_is_null),
    .out_record_done  (out_record_done),
    .out_record_length(out_record_length),
    .out_oversize     (out_oversize),
    .out_last_in_run  (out_last_in_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Directory model
  // --------------------------------------------------------------------------
  function automatic int unsigned active_fields();
    int unsigned cnt;
    cnt = cfg_fields;
    if (cnt == 0) cnt = 1;
    if (cnt > FIELD_LIMIT) cnt = FIELD_LIMIT;
    return cnt;
  endfunction

  function automatic void restart_record(inout parser_state_t s);
    s = '0;
    s.phase = PH_BITMAP;
  endfunction

  function automatic void release_entry(input parser_state_t s, input int unsigned idx,
                                        input logic nul);
    dir_entry_t  e;
    int unsigned cnt;
    logic [16:0] off;
    cnt = active_fields();
    off = (s.offset > 17'd65535) ? 17'd65535 : s.offset;
    e.field_index = idx[4:0];
    e.end_offset = off[15:0];
    e.is_null = nul;
    e.done = (idx + 1 >= cnt);
    e.rec_len = e.done ? 17'((cnt + 7) / 8 + off) : 17'd0;
    e.oversize = (s.offset > 17'd65535);
    e.last_in_run = 1'b0;
    step_entries.push_back(e);
  endfunction

  // Emit entries for fields that need no bytes, then arm the next field.
  function automatic void walk_fields(inout parser_state_t s);
    int unsigned cnt;
    int unsigned i;
    cnt = active_fields();
    while (s.field_cur < cnt) begin
      i = s.field_cur;
      if (s.null_bits[i]) begin
        release_entry(s, i, 1'b1);
        s.field_cur = s.field_cur + 1'b1;
      end else if (cfg_varchar[i]) begin
        s.phase = PH_LENGTH;
        s.len_acc = '0;
        s.len_seen = '0;
        return;
      end else if (cfg_fixed == 4'd0) begin
        release_entry(s, i, 1'b0);
        s.field_cur = s.field_cur + 1'b1;
      end else begin
        s.remaining = 32'(cfg_fixed);
        s.phase = PH_BODY;
        return;
      end
    end
    restart_record(s);
  endfunction

  function automatic void close_field(inout parser_state_t s);
    release_entry(s, s.field_cur, 1'b0);
    s.field_cur = s.field_cur + 1'b1;
    if (s.field_cur >= active_fields()) restart_record(s);
    else walk_fields(s);
  endfunction

  // Advance the model by one record byte; entries land in step_entries.
  function automatic void parse_byte(inout parser_state_t s, input logic [7:0] b);
    int unsigned nb;
    int          k;
    int          pos;
    dir_entry_t  tail;
    step_entries.delete();
    case (s.phase)
      PH_LENGTH: begin
        s.len_acc = s.len_acc | (32'(b) << (8 * s.len_seen[1:0]));
        s.len_seen = s.len_seen + 1'b1;
        if (s.offset < 17'd65536) s.offset = s.offset + 1'b1;
        if (s.len_seen >= 3'd4) begin
          s.remaining = s.len_acc;
          s.len_acc = '0;
          s.len_seen = '0;
          if (s.remaining == 0) close_field(s);
          else s.phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (s.offset < 17'd65536) s.offset = s.offset + 1'b1;
        if (s.remaining > 0) s.remaining = s.remaining - 1;
        if (s.remaining == 0) close_field(s);
      end
      default: begin
        nb = (active_fields() + 7) / 8;
        if (s.bitmap_seen == 0) s.null_bits = '0;
        // MSB of the byte is the lowest field of its group of eight
        for (k = 0; k < 8; k++) begin
          pos = s.bitmap_seen[2:0] * 8 + k;
          if (b[7 - k]) s.null_bits[pos] = 1'b1;
        end
        s.bitmap_seen = s.bitmap_seen + 1'b1;
        if (s.bitmap_seen >= nb) begin
          s.bitmap_seen = '0;
          s.field_cur = '0;
          s.offset = '0;
          walk_fields(s);
        end
      end
    endcase
    if (step_entries.size() != 0) begin
      tail = step_entries.pop_back();
      tail.last_in_run = 1'b1;
      step_entries.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Choose a byte that keeps varchar lengths short enough to finish.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(9);
    case (shadow_parser.phase)
      PH_LENGTH: begin
        case (shadow_parser.len_seen)
          3'd0: begin
            if (r < 2) return 8'h00;
            if (r < 8) return 8'($urandom_range(1, 24));
            if (r == 8) return 8'($urandom_range(0, 255));
            return 8'($urandom_range(25, 120));
          end
          default: return 8'h00;
        endcase
      end
      PH_BODY: return 8'($urandom());
      default: begin
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom());
      end
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_pushed++;
    parse_byte(shadow_parser, b);
    gen_entries += step_entries.size();
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 46; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 46; end
      default: begin send_idle_pct = 37; stall_pct = 37; end
    endcase
  endtask

  // Hold the sender until every byte is taken and every entry has arrived.
  task automatic wait_idle();
    while (bytes_taken != bytes_pushed || expected_entries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_writes++;
    case (idx)
      CFG_FIELD_COUNT:  cfg_fields = val[5:0];
      CFG_VARCHAR_MASK: cfg_varchar = val;
      CFG_FIXED_WIDTH:  cfg_fixed = val[3:0];
      default: ;
    endcase
  endtask

  // Upper bits of the narrow registers carry junk; the block must drop them.
  task automatic set_layout(input logic [5:0] fields, input logic [31:0] vmask,
                            input logic [3:0] width);
    write_reg(CFG_FIELD_COUNT, {26'($urandom()), fields});
    write_reg(CFG_VARCHAR_MASK, vmask);
    write_reg(CFG_FIXED_WIDTH, {28'($urandom()), width});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Driver: one record byte per transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'h00;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(live_parser, in_data_byte);
        foreach (step_entries[j]) expected_entries.push_back(step_entries[j]);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each directory entry with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : entry_monitor
    dir_entry_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_entries.size() == 0) begin
          $error("unexpected directory entry for field %0d", out_field_index);
          mismatch_count++;
        end else begin
          want = expected_entries.pop_front();
          if (out_field_index !== want.field_index) begin
            $error("field_index: expected %0d, got %0d", want.field_index, out_field_index);
            mismatch_count++;
          end
          if (out_end_offset !== want.end_offset) begin
            $error("end_offset: expected %0d, got %0d", want.end_offset, out_end_offset);
            mismatch_count++;
          end
          if (out_field_is_null !== want.is_null) begin
            $error("field_is_null: expected %0d, got %0d", want.is_null, out_field_is_null);
            mismatch_count++;
          end
          if (out_record_done !== want.done) begin
            $error("record_done: expected %0d, got %0d", want.done, out_record_done);
            mismatch_count++;
          end
          if (out_record_length !== want.rec_len) begin
            $error("record_length: expected %0d, got %0d", want.rec_len, out_record_length);
            mismatch_count++;
          end
          if (out_oversize !== want.oversize) begin
            $error("oversize: expected %0d, got %0d", want.oversize, out_oversize);
            mismatch_count++;
          end
          if (out_last_in_run !== want.last_in_run) begin
            $error("last_in_run: expected %0d, got %0d", want.last_in_run, out_last_in_run);
            mismatch_count++;
          end
          entries_checked++;
          if (want.done) records_closed++;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL record_field_directory_parser_unit");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int          p;
    logic [5:0]  fc;
    logic [31:0] vm;
    logic [3:0]  fw;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FIELD_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    out_stall = 1'b0;
    cfg_fields = FIELD_COUNT_RST;
    cfg_varchar = '0;
    cfg_fixed = FIXED_WIDTH_RST;
    restart_record(live_parser);
    restart_record(shadow_parser);
    send_idle_pct = 0;
    stall_pct = 0;
    bytes_pushed = 0;
    bytes_taken = 0;
    gen_entries = 0;
    entries_checked = 0;
    records_closed = 0;
    cfg_writes = 0;
    mismatch_count = 0;
    cycle_count = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset layout: one 4-byte fixed field, then the same field null
    set_idling(0);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hA5);
    push_byte(8'h5A);
    push_byte(8'h80);
    wait_idle();

    // zero field count acts as one field; zero-width fixed field ends at once
    set_idling(1);
    write_reg(CFG_UNUSED, $urandom());
    set_layout(6'd0, 32'h0, 4'd0);
    push_byte(8'h00);
    wait_idle();

    // field count above the limit, every field null: one byte frees 32 entries
    set_idling(2);
    set_layout(6'd63, 32'hFFFF_FFFF, 4'd15);
    repeat (4) push_byte(8'hFF);
    wait_idle();

    // empty varchar followed by a null field, both released by one length byte
    set_idling(3);
    set_layout(6'd3, 32'h0000_0002, 4'd1);
    push_byte(8'h20);
    push_byte(8'h7E);
    repeat (4) push_byte(8'h00);
    wait_idle();

    // random layouts; bursts may end mid-record so the layout changes under it
    p = 0;
    while (p < 8 || gen_entries < 80) begin
      set_idling(p % 4);
      case ($urandom_range(7))
        0: fc = 6'd1;
        1: fc = 6'd32;
        2: fc = 6'($urandom_range(33, 63));
        3: fc = 6'd0;
        default: fc = 6'($urandom_range(2, 8));
      endcase
      case ($urandom_range(3))
        0: vm = 32'h0;
        1: vm = 32'hFFFF_FFFF;
        default: vm = $urandom();
      endcase
      case ($urandom_range(5))
        0: fw = 4'd0;
        1: fw = 4'd15;
        default: fw = 4'($urandom_range(1, 4));
      endcase
      set_layout(fc, vm, fw);
      repeat (21) push_byte(pick_byte());
      if (p == 2) wait_idle();
      repeat (21) push_byte(pick_byte());
      wait_idle();
      p++;
    end

    // close the open record
    while (shadow_parser.phase != PH_BITMAP || shadow_parser.bitmap_seen != 0)
      push_byte(pick_byte());
    wait_idle();
    repeat (32) @(posedge clk);

    $display("Checked %0d directory entries (%0d record ends) from %0d bytes, %0d reg writes.",
             entries_checked, records_closed, bytes_taken, cfg_writes);
    $display("Covered null runs, empty varchars, zero-width fields and layout changes.");
    if (mismatch_count == 0) begin
      $display("PASS record_field_directory_parser_unit");
    end else begin
      $display("FAIL record_field_directory_parser_unit");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rfdp_pkg.sv
rtl/rfdp_ctrl.sv
rtl/rfdp_dpath.sv
rtl/record_field_directory_parser_unit.sv
verif/record_field_directory_parser_unit_tb.sv
